// ===== sv/apeg_pkg.sv =====
// ----------------------------------------------------------------------------
// Peak / energy grid package
// Shared constants, operation codes and register indexes for the peak and
// energy decimation grid.
// ----------------------------------------------------------------------------
package apeg_pkg;

   // Default sizes for the top-level parameters.
   localparam int GRID_DEPTH_DEF   = 16384;
   localparam int MAX_CHANNELS_DEF = 2;
   localparam int SAMPLE_BITS_DEF  = 24;

   // Operation codes of an input beat.
   localparam int OP_BITS = 2;
   localparam logic [OP_BITS-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_READ   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_FINISH = 2'd2;

   // Fixed field widths.
   localparam int ENERGY_BITS = 64;
   localparam int SPAN_BITS   = 6;
   localparam int FRAME_BITS  = 48;

   // The span stops growing here so that a sub-bucket length fits the frame counter.
   localparam logic [SPAN_BITS-1:0] SPAN_CAP = 6'd47;

   // Configuration registers.
   localparam int CFG_CHAN_BITS  = 2;
   localparam int CFG_GRID_BITS  = 15;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 15;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_ENTRIES  = 4'd1;

   localparam logic [CFG_CHAN_BITS-1:0] CHANNEL_COUNT_RST = 2'd2;
   localparam logic [CFG_GRID_BITS-1:0] GRID_ENTRIES_RST  = 15'd16384;
   localparam logic [CFG_GRID_BITS-1:0] GRID_MIN          = 15'd4;

endpackage

// ===== sv/apeg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module apeg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 write_en,
   input  logic [ADDR_BITS-1:0] write_addr,
   input  logic [WIDTH-1:0]     write_data,
   input  logic [ADDR_BITS-1:0] read_addr,
   output logic [WIDTH-1:0]     read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== sv/apeg_square.sv =====
// ----------------------------------------------------------------------------
// Sample magnitude and square
// Takes the magnitude of a two's complement sample and squares it.
// ----------------------------------------------------------------------------
module apeg_square #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic signed [SAMPLE_BITS-1:0]   sample,
   output logic        [SAMPLE_BITS-1:0]   magnitude,
   output logic        [2*SAMPLE_BITS-1:0] square
);

   logic [SAMPLE_BITS-1:0] raw;

   // The most negative sample maps to 2^(SAMPLE_BITS-1), which still fits unsigned.
   assign raw       = sample;
   assign magnitude = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
   assign square    = (2*SAMPLE_BITS)'(magnitude) * (2*SAMPLE_BITS)'(magnitude);

endmodule

// ===== sv/apeg_combine.sv =====
// ----------------------------------------------------------------------------
// Peak / energy combine unit
// Maximum of two peaks and saturating sum of two energies.
// ----------------------------------------------------------------------------
module apeg_combine #(
   parameter int PEAK_BITS = 24
) (
   input  logic [PEAK_BITS-1:0]             peak_a,
   input  logic [PEAK_BITS-1:0]             peak_b,
   input  logic [apeg_pkg::ENERGY_BITS-1:0] energy_a,
   input  logic [apeg_pkg::ENERGY_BITS-1:0] energy_b,
   output logic [PEAK_BITS-1:0]             peak_max,
   output logic [apeg_pkg::ENERGY_BITS-1:0] energy_total
);

   import apeg_pkg::*;

   logic [ENERGY_BITS:0] wide_sum;

   assign peak_max     = (peak_a > peak_b) ? peak_a : peak_b;
   assign wide_sum     = {1'b0, energy_a} + {1'b0, energy_b};
   assign energy_total = wide_sum[ENERGY_BITS] ? '1 : wide_sum[ENERGY_BITS-1:0];

endmodule

// ===== sv/adaptive_peak_energy_grid.sv =====
// ----------------------------------------------------------------------------
// Adaptive peak / energy grid
// Per-channel peak and energy decimation of interleaved audio into a grid of
// sub-buckets that halves its resolution whenever it fills.
// ----------------------------------------------------------------------------
// Usage: an input beat is taken when start is high and busy is low. A push
// (req_operation 0) adds one sample to the open sub-bucket of its channel; a
// read (1) returns one stored grid entry; finish (2) stores the partial
// sub-bucket and reports the fill state. Code 3 is dropped. Read and finish
// give one result beat, marked by rsp_valid for exactly one cycle; the
// receiver cannot stall, so the block never waits on it.
// Sequence: a push is accepted, then accumulated in the shared compare / add
// unit. The push that closes a sub-bucket then makes one memory write per
// channel. When the grid fills, the merge walks the store through its single
// read port: per channel it reads each even / odd pair, writes the combined
// entry, then clears the upper part of the channel. A read passes through the
// store address and data states before its result; a finish reports straight
// from accept, or after the open sub-buckets are stored.
// Reset: the store is cleared one entry per cycle, with busy high;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module adaptive_peak_energy_grid #(
   parameter int GRID_DEPTH   = apeg_pkg::GRID_DEPTH_DEF,
   parameter int MAX_CHANNELS = apeg_pkg::MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = apeg_pkg::SAMPLE_BITS_DEF,
   localparam int CH_BITS  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int IDX_BITS = $clog2(GRID_DEPTH),
   localparam int CNT_BITS = $clog2(GRID_DEPTH + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   start,
   output logic                                   busy,
   input  logic [apeg_pkg::OP_BITS-1:0]           req_operation,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample,
   input  logic [CH_BITS-1:0]                     req_channel,
   input  logic [IDX_BITS-1:0]                    req_entry_index,

   output logic                                   rsp_valid,
   output logic [SAMPLE_BITS-1:0]                 rsp_peak_level,
   output logic [apeg_pkg::ENERGY_BITS-1:0]       rsp_energy_sum,
   output logic [CNT_BITS-1:0]                    rsp_entry_total,
   output logic [apeg_pkg::SPAN_BITS-1:0]         rsp_span_exponent,
   output logic [apeg_pkg::FRAME_BITS-1:0]        rsp_leftover_frames,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [apeg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [apeg_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   import apeg_pkg::*;

   // Store layout: entry k of channel c lives at c * GRID_DEPTH + k.
   localparam int STORE_DEPTH = GRID_DEPTH * MAX_CHANNELS;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int WORD_BITS   = SAMPLE_BITS + ENERGY_BITS;
   localparam int GW          = ((CNT_BITS > CFG_GRID_BITS) ? CNT_BITS : CFG_GRID_BITS) + 1;

   localparam logic [GW-1:0]        GRID_EVEN_MAX = GW'(GRID_DEPTH) & ~GW'(1);
   localparam logic [GW-1:0]        GRID_FLOOR    = GW'(GRID_MIN);
   localparam logic [3:0]           MAX_CH4       = 4'(MAX_CHANNELS);
   localparam logic [ADDR_BITS-1:0] CLEAR_LAST    = ADDR_BITS'(STORE_DEPTH - 1);
   localparam logic [ADDR_BITS-1:0] BASE_STEP     = ADDR_BITS'(GRID_DEPTH);
   localparam logic [CNT_BITS-1:0]  ENTRY_LAST    = CNT_BITS'(GRID_DEPTH - 1);
   localparam logic [CNT_BITS-1:0]  ENTRY_LIMIT   = CNT_BITS'(GRID_DEPTH);
   localparam logic [CH_BITS-1:0]   CHAN_LAST     = CH_BITS'(MAX_CHANNELS - 1);

   // Sequencer states.
   localparam int STATE_BITS = 4;
   localparam logic [STATE_BITS-1:0] S_CLEAR = 4'd0;  // clearing pass after reset
   localparam logic [STATE_BITS-1:0] S_IDLE  = 4'd1;
   localparam logic [STATE_BITS-1:0] S_ACC   = 4'd2;  // fold a sample into its channel
   localparam logic [STATE_BITS-1:0] S_WOPEN = 4'd3;  // store open sub-buckets
   localparam logic [STATE_BITS-1:0] S_RD    = 4'd4;  // read address to the store
   localparam logic [STATE_BITS-1:0] S_RDATA = 4'd5;  // read data back, build result
   localparam logic [STATE_BITS-1:0] S_MRDA  = 4'd6;  // merge: fetch even entry
   localparam logic [STATE_BITS-1:0] S_MRDB  = 4'd7;  // merge: fetch odd entry
   localparam logic [STATE_BITS-1:0] S_MWR   = 4'd8;  // merge: write combined entry
   localparam logic [STATE_BITS-1:0] S_MCLR  = 4'd9;  // merge: clear upper part

   // Control state.
   logic [STATE_BITS-1:0]    state_ff, state_in;
   logic [ADDR_BITS-1:0]     clr_addr_ff, clr_addr_in;
   logic                     close_mode_ff, close_mode_in;
   logic [CH_BITS-1:0]       chan_ff, chan_in;
   logic [ADDR_BITS-1:0]     base_ff, base_in;
   logic [CNT_BITS-1:0]      k_ff, k_in;

   // Grid and sub-bucket bookkeeping.
   logic [CNT_BITS-1:0]      filled_ff, filled_in;
   logic [SPAN_BITS-1:0]     span_ff, span_in;
   logic [FRAME_BITS-1:0]    limit_ff, limit_in;
   logic [FRAME_BITS-1:0]    frames_ff, frames_in;
   logic [SAMPLE_BITS-1:0]   open_peak_ff   [MAX_CHANNELS];
   logic [SAMPLE_BITS-1:0]   open_peak_in   [MAX_CHANNELS];
   logic [ENERGY_BITS-1:0]   open_energy_ff [MAX_CHANNELS];
   logic [ENERGY_BITS-1:0]   open_energy_in [MAX_CHANNELS];

   // Configuration.
   logic [CFG_CHAN_BITS-1:0] channel_count_ff, channel_count_in;
   logic [CFG_GRID_BITS-1:0] grid_entries_ff, grid_entries_in;

   // Captured request and merge operand.
   logic [CH_BITS-1:0]       ch_ff, ch_in;
   logic [IDX_BITS-1:0]      idx_ff, idx_in;
   logic [SAMPLE_BITS-1:0]   mag_ff, mag_in;
   logic [2*SAMPLE_BITS-1:0] sq_ff, sq_in;
   logic [SAMPLE_BITS-1:0]   a_peak_ff, a_peak_in;
   logic [ENERGY_BITS-1:0]   a_energy_ff, a_energy_in;

   // Result registers.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]   rsp_peak_ff, rsp_peak_in;
   logic [ENERGY_BITS-1:0]   rsp_energy_ff, rsp_energy_in;
   logic [CNT_BITS-1:0]      rsp_total_ff, rsp_total_in;
   logic [SPAN_BITS-1:0]     rsp_span_ff, rsp_span_in;
   logic [FRAME_BITS-1:0]    rsp_frames_ff, rsp_frames_in;

   // Datapath signals.
   logic [SAMPLE_BITS-1:0]   in_mag;
   logic [2*SAMPLE_BITS-1:0] in_sq;
   logic [CH_BITS-1:0]       acc_ch;
   logic [SAMPLE_BITS-1:0]   cmb_peak_a, cmb_peak_b, cmb_peak;
   logic [ENERGY_BITS-1:0]   cmb_energy_a, cmb_energy_b, cmb_energy;
   logic                     ram_we;
   logic [ADDR_BITS-1:0]     ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0]     ram_wdata, ram_rdata;
   logic [SAMPLE_BITS-1:0]   rd_peak;
   logic [ENERGY_BITS-1:0]   rd_energy;
   logic [GW-1:0]            grid_even, grid_wide;
   logic [CNT_BITS-1:0]      grid_eff, grid_half;
   logic [3:0]               cc4, last4, ch4;
   logic                     push_ok, push_last, rd_ok;
   logic [FRAME_BITS-1:0]    frames_next;
   logic [CNT_BITS-1:0]      filled_next;
   logic [CNT_BITS-1:0]      off_even;

   // Magnitude and square of the incoming sample, registered at accept.
   apeg_square #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_square (
      .sample    (req_sample),
      .magnitude (in_mag),
      .square    (in_sq)
   );

   // The one compare / saturating-add unit. It folds a sample into an open
   // sub-bucket during a push and combines two stored entries during a merge.
   always_comb begin
      acc_ch = (state_ff == S_ACC) ? ch_ff : chan_ff;
      if (state_ff == S_MWR) begin
         cmb_peak_a   = a_peak_ff;
         cmb_energy_a = a_energy_ff;
         cmb_peak_b   = rd_peak;
         cmb_energy_b = rd_energy;
      end else begin
         cmb_peak_a   = open_peak_ff[acc_ch];
         cmb_energy_a = open_energy_ff[acc_ch];
         cmb_peak_b   = mag_ff;
         cmb_energy_b = ENERGY_BITS'(sq_ff);
      end
   end

   apeg_combine #(
      .PEAK_BITS (SAMPLE_BITS)
   ) u_combine (
      .peak_a       (cmb_peak_a),
      .peak_b       (cmb_peak_b),
      .energy_a     (cmb_energy_a),
      .energy_b     (cmb_energy_b),
      .peak_max     (cmb_peak),
      .energy_total (cmb_energy)
   );

   // Peak and energy of every channel's grid entries, one word per entry.
   apeg_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata)
   );

   assign rd_peak   = ram_rdata[WORD_BITS-1 -: SAMPLE_BITS];
   assign rd_energy = ram_rdata[ENERGY_BITS-1:0];

   // Effective grid size: even, at least four, at most GRID_DEPTH rounded down to even.
   always_comb begin
      grid_even = GW'({grid_entries_ff[CFG_GRID_BITS-1:1], 1'b0});
      if (grid_even < GRID_FLOOR) begin
         grid_wide = GRID_FLOOR;
      end else if (grid_even > GRID_EVEN_MAX) begin
         grid_wide = GRID_EVEN_MAX;
      end else begin
         grid_wide = grid_even;
      end
      grid_eff  = CNT_BITS'(grid_wide);
      grid_half = grid_eff >> 1;
   end

   // Last channel of a frame. A count of zero acts as one channel, and a
   // count above the channel capacity acts as the capacity.
   always_comb begin
      cc4 = 4'(channel_count_ff);
      ch4 = 4'(ch_ff);
      if (cc4 == 4'd0) begin
         last4 = 4'd0;
      end else if (cc4 > MAX_CH4) begin
         last4 = MAX_CH4 - 4'd1;
      end else begin
         last4 = cc4 - 4'd1;
      end
      push_ok   = (ch4 <= last4);
      push_last = (ch4 == last4);
   end

   // A read outside the channel capacity or the grid depth returns zero.
   assign rd_ok = (4'(ch_ff) < MAX_CH4) && ({1'b0, idx_ff} < (IDX_BITS + 1)'(GRID_DEPTH));

   assign frames_next = frames_ff + 1'b1;
   assign filled_next = filled_ff + 1'b1;
   assign off_even    = k_ff << 1;

   always_comb begin
      state_in         = state_ff;
      clr_addr_in      = clr_addr_ff;
      close_mode_in    = close_mode_ff;
      chan_in          = chan_ff;
      base_in          = base_ff;
      k_in             = k_ff;
      filled_in        = filled_ff;
      span_in          = span_ff;
      limit_in         = limit_ff;
      frames_in        = frames_ff;
      open_peak_in     = open_peak_ff;
      open_energy_in   = open_energy_ff;
      channel_count_in = channel_count_ff;
      grid_entries_in  = grid_entries_ff;
      ch_in            = ch_ff;
      idx_in           = idx_ff;
      mag_in           = mag_ff;
      sq_in            = sq_ff;
      a_peak_in        = a_peak_ff;
      a_energy_in      = a_energy_ff;
      rsp_valid_in     = 1'b0;
      rsp_peak_in      = rsp_peak_ff;
      rsp_energy_in    = rsp_energy_ff;
      rsp_total_in     = rsp_total_ff;
      rsp_span_in      = rsp_span_ff;
      rsp_frames_in    = rsp_frames_ff;
      ram_we           = 1'b0;
      ram_waddr        = base_ff + ADDR_BITS'(k_ff);
      ram_wdata        = '0;
      ram_raddr        = base_ff + ADDR_BITS'(off_even);

      // Configuration writes are taken in any state.
      if (csr_valid) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: channel_count_in = csr_data[CFG_CHAN_BITS-1:0];
            CSR_GRID_ENTRIES:  grid_entries_in  = csr_data[CFG_GRID_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            if (clr_addr_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (start) begin
               ch_in  = req_channel;
               idx_in = req_entry_index;
               mag_in = in_mag;
               sq_in  = in_sq;
               case (req_operation)
                  OP_PUSH: state_in = S_ACC;
                  OP_READ: state_in = S_RD;
                  OP_FINISH: begin
                     if (frames_ff != '0) begin
                        close_mode_in = 1'b0;
                        chan_in       = '0;
                        base_in       = '0;
                        state_in      = S_WOPEN;
                     end else begin
                        // Nothing open: report straight away.
                        rsp_valid_in  = 1'b1;
                        rsp_peak_in   = '0;
                        rsp_energy_in = '0;
                        rsp_total_in  = filled_ff;
                        rsp_span_in   = span_ff;
                        rsp_frames_in = frames_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_ACC: begin
            state_in = S_IDLE;
            if (push_ok) begin
               open_peak_in[ch_ff]   = cmb_peak;
               open_energy_in[ch_ff] = cmb_energy;
               if (push_last) begin
                  // The open sub-bucket holds exactly limit_ff frames when full.
                  if (frames_next == limit_ff) begin
                     frames_in     = '0;
                     close_mode_in = 1'b1;
                     chan_in       = '0;
                     base_in       = '0;
                     state_in      = S_WOPEN;
                  end else begin
                     frames_in = frames_next;
                  end
               end
            end
         end

         S_WOPEN: begin
            ram_we    = (filled_ff < ENTRY_LIMIT);
            ram_waddr = base_ff + ADDR_BITS'(filled_ff);
            ram_wdata = {open_peak_ff[acc_ch], open_energy_ff[acc_ch]};
            if (close_mode_ff) begin
               open_peak_in[acc_ch]   = '0;
               open_energy_in[acc_ch] = '0;
            end
            if (chan_ff == CHAN_LAST) begin
               if (close_mode_ff) begin
                  if (filled_next >= grid_eff) begin
                     chan_in  = '0;
                     base_in  = '0;
                     k_in     = '0;
                     state_in = S_MRDA;
                  end else begin
                     filled_in = filled_next;
                     state_in  = S_IDLE;
                  end
               end else begin
                  // Finish: the partial sub-bucket counts as one more entry.
                  rsp_valid_in  = 1'b1;
                  rsp_peak_in   = '0;
                  rsp_energy_in = '0;
                  rsp_total_in  = filled_next;
                  rsp_span_in   = span_ff;
                  rsp_frames_in = frames_ff;
                  state_in      = S_IDLE;
               end
            end else begin
               chan_in = chan_ff + 1'b1;
               base_in = base_ff + BASE_STEP;
            end
         end

         S_RD: begin
            ram_raddr = ADDR_BITS'(ch_ff) * BASE_STEP + ADDR_BITS'(idx_ff);
            state_in  = S_RDATA;
         end

         S_RDATA: begin
            rsp_valid_in  = 1'b1;
            rsp_peak_in   = rd_ok ? rd_peak : '0;
            rsp_energy_in = rd_ok ? rd_energy : '0;
            rsp_total_in  = filled_ff;
            rsp_span_in   = span_ff;
            rsp_frames_in = frames_ff;
            state_in      = S_IDLE;
         end

         S_MRDA: begin
            ram_raddr = base_ff + ADDR_BITS'(off_even);
            state_in  = S_MRDB;
         end

         S_MRDB: begin
            ram_raddr   = base_ff + ADDR_BITS'(off_even | CNT_BITS'(1));
            a_peak_in   = rd_peak;
            a_energy_in = rd_energy;
            state_in    = S_MWR;
         end

         S_MWR: begin
            // Entry k is written only after entries 2k and 2k+1 were read.
            ram_we    = 1'b1;
            ram_waddr = base_ff + ADDR_BITS'(k_ff);
            ram_wdata = {cmb_peak, cmb_energy};
            k_in      = k_ff + 1'b1;
            if ((k_ff + 1'b1) == grid_half) begin
               state_in = S_MCLR;
            end else begin
               state_in = S_MRDA;
            end
         end

         S_MCLR: begin
            // Every entry of the channel from half the grid up to GRID_DEPTH - 1 is cleared.
            ram_we    = 1'b1;
            ram_waddr = base_ff + ADDR_BITS'(k_ff);
            if (k_ff == ENTRY_LAST) begin
               if (chan_ff == CHAN_LAST) begin
                  filled_in = grid_half;
                  if (span_ff < SPAN_CAP) begin
                     span_in  = span_ff + 1'b1;
                     limit_in = limit_ff << 1;
                  end
                  state_in = S_IDLE;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  base_in  = base_ff + BASE_STEP;
                  k_in     = '0;
                  state_in = S_MRDA;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control and model state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_addr_ff      <= '0;
         close_mode_ff    <= 1'b0;
         chan_ff          <= '0;
         base_ff          <= '0;
         k_ff             <= '0;
         filled_ff        <= '0;
         span_ff          <= '0;
         limit_ff         <= FRAME_BITS'(1);
         frames_ff        <= '0;
         channel_count_ff <= CHANNEL_COUNT_RST;
         grid_entries_ff  <= GRID_ENTRIES_RST;
         rsp_valid_ff     <= 1'b0;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            open_peak_ff[c]   <= '0;
            open_energy_ff[c] <= '0;
         end
      end else begin
         state_ff         <= state_in;
         clr_addr_ff      <= clr_addr_in;
         close_mode_ff    <= close_mode_in;
         chan_ff          <= chan_in;
         base_ff          <= base_in;
         k_ff             <= k_in;
         filled_ff        <= filled_in;
         span_ff          <= span_in;
         limit_ff         <= limit_in;
         frames_ff        <= frames_in;
         channel_count_ff <= channel_count_in;
         grid_entries_ff  <= grid_entries_in;
         rsp_valid_ff     <= rsp_valid_in;
         open_peak_ff     <= open_peak_in;
         open_energy_ff   <= open_energy_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      idx_ff        <= idx_in;
      mag_ff        <= mag_in;
      sq_ff         <= sq_in;
      a_peak_ff     <= a_peak_in;
      a_energy_ff   <= a_energy_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_span_ff   <= rsp_span_in;
      rsp_frames_ff <= rsp_frames_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_peak_level      = rsp_peak_ff;
   assign rsp_energy_sum      = rsp_energy_ff;
   assign rsp_entry_total     = rsp_total_ff;
   assign rsp_span_exponent   = rsp_span_ff;
   assign rsp_leftover_frames = rsp_frames_ff;

endmodule
